// ===== rtl/hel_pkg.sv =====
package hel_pkg;

    localparam int MAX_WIDTH_DEF = 1024;

    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef logic [1:0] t_class;

    localparam t_class CLASS_WEAK   = 2'd1;
    localparam t_class CLASS_STRONG = 2'd2;

    localparam logic [7:0] PIXEL_ON  = 8'd255;
    localparam logic [7:0] PIXEL_OFF = 8'd0;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_result;

endpackage

// ===== rtl/hel_ram.sv =====
module hel_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/hel_front.sv =====
module hel_front import hel_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  t_class                  i_class,
    input  logic [((($clog2(MAX_WIDTH) + 1) > WIDTH_REG_W) ?
                   ($clog2(MAX_WIDTH) + 1) : WIDTH_REG_W)-1:0] i_width,
    input  logic [HEIGHT_REG_W-1:0] i_height,
    input  logic                    i_restart,
    output logic                    o_reserve,
    output logic                    o_res_valid,
    output t_result                 o_result
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ((CW + 1) > WIDTH_REG_W) ? (CW + 1) : WIDTH_REG_W;

    // Input position counters; the row count only needs to tell 0, 1 and 2 or more apart.
    logic [CW-1:0]           r_ic, n_ic;
    logic [1:0]              r_in_row, n_in_row;
    logic [CW-1:0]           r_oc, n_oc;
    logic [HEIGHT_REG_W-1:0] r_or, n_or;

    logic ic_last, started, top, bottom, left, right, last;

    // Stage one: line store data arrives, window shifts, the pixel is decided.
    logic          r_v1;
    t_class        r_cls;
    logic [CW-1:0] r_addr;
    logic          r_started, r_top, r_bottom, r_left, r_right, r_last;
    logic          r_fwd;
    logic [3:0]    r_fwd_data;

    logic [3:0] ram_q, line_data;
    t_class     up, mid, center;
    t_class     r_win_c1 [3];
    t_class     r_win_c2 [3];
    logic       strong_near;

    assign ic_last = (WW'(r_ic) + WW'(1)) >= i_width;
    assign started = (r_in_row == 2'd2) || ((r_in_row == 2'd1) && (r_ic != '0));
    assign top     = (r_or == '0);
    assign bottom  = ({1'b0, r_or} + (HEIGHT_REG_W + 1)'(1)) >= {1'b0, i_height};
    assign left    = (r_oc == '0);
    assign right   = (WW'(r_oc) + WW'(1)) >= i_width;
    assign last    = started && bottom && right;

    assign o_reserve = i_accept && started;

    always_comb begin
        n_ic     = r_ic;
        n_in_row = r_in_row;
        n_oc     = r_oc;
        n_or     = r_or;
        if (i_restart) begin
            n_ic     = '0;
            n_in_row = '0;
            n_oc     = '0;
            n_or     = '0;
        end else if (i_accept) begin
            if (last) begin
                n_ic     = '0;
                n_in_row = '0;
                n_oc     = '0;
                n_or     = '0;
            end else begin
                if (ic_last) begin
                    n_ic = '0;
                    if (r_in_row != 2'd2) begin
                        n_in_row = r_in_row + 2'd1;
                    end
                end else begin
                    n_ic = r_ic + CW'(1);
                end
                if (started) begin
                    if (right) begin
                        n_oc = '0;
                        n_or = r_or + HEIGHT_REG_W'(1);
                    end else begin
                        n_oc = r_oc + CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic     <= '0;
            r_in_row <= '0;
            r_oc     <= '0;
            r_or     <= '0;
            r_v1     <= 1'b0;
        end else begin
            r_ic     <= n_ic;
            r_in_row <= n_in_row;
            r_oc     <= n_oc;
            r_or     <= n_or;
            r_v1     <= i_accept;
        end
    end

    // A line store read that meets the write of the item ahead at the same column
    // sees stale data, so that write is forwarded instead.
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cls     <= i_class;
            r_addr    <= r_ic;
            r_started <= started;
            r_top     <= top;
            r_bottom  <= bottom;
            r_left    <= left;
            r_right   <= right;
            r_last    <= last;
            r_fwd     <= r_v1 && (r_addr == r_ic);
        end
        if (r_v1) begin
            r_fwd_data <= {mid, r_cls};
        end
    end

    hel_ram #(
        .WIDTH (4),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_v1),
        .i_waddr (r_addr),
        .i_wdata ({mid, r_cls}),
        .i_raddr (r_ic),
        .o_rdata (ram_q)
    );

    assign line_data = r_fwd ? r_fwd_data : ram_q;
    assign up        = line_data[3:2];
    assign mid       = line_data[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_win_c1[r] <= '0;
                r_win_c2[r] <= '0;
            end
        end else if (r_v1) begin
            for (int r = 0; r < 3; r++) begin
                r_win_c1[r] <= r_win_c2[r];
            end
            r_win_c2[0] <= up;
            r_win_c2[1] <= mid;
            r_win_c2[2] <= r_cls;
        end
    end

    // After the shift the left column is the old middle one, the center the old
    // right one, and the right column the incoming data.
    always_comb begin
        strong_near = 1'b0;
        if (!r_top) begin
            if (!r_left && (r_win_c1[0] == CLASS_STRONG)) strong_near = 1'b1;
            if (r_win_c2[0] == CLASS_STRONG) strong_near = 1'b1;
            if (!r_right && (up == CLASS_STRONG)) strong_near = 1'b1;
        end
        if (!r_left && (r_win_c1[1] == CLASS_STRONG)) strong_near = 1'b1;
        if (!r_right && (mid == CLASS_STRONG)) strong_near = 1'b1;
        if (!r_bottom) begin
            if (!r_left && (r_win_c1[2] == CLASS_STRONG)) strong_near = 1'b1;
            if (r_win_c2[2] == CLASS_STRONG) strong_near = 1'b1;
            if (!r_right && (r_cls == CLASS_STRONG)) strong_near = 1'b1;
        end
    end

    assign center = r_win_c2[1];

    always_comb begin
        if (center == CLASS_STRONG) begin
            o_result.value = PIXEL_ON;
        end else if ((center == CLASS_WEAK) && strong_near) begin
            o_result.value = PIXEL_ON;
        end else begin
            o_result.value = PIXEL_OFF;
        end
        o_result.last = r_last;
    end

    assign o_res_valid = r_v1 && r_started;

endmodule

// ===== rtl/hel_fifo.sv =====
module hel_fifo import hel_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [NW-1:0]   r_count;
    logic            pop_ok;

    assign o_empty = (r_count == '0);
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            r_count <= r_count + NW'(i_push) - NW'(pop_ok);
        end
    end

endmodule

// ===== rtl/hysteresis_edge_link_3x3.sv =====
// Result for an item is pushed into the result queue in the cycle after the item is
// taken, once the window has filled (the first row plus one pixel gives no result).
// Throughput is one item per cycle unless full; the line store is a single memory,
// read every cycle and written per item taken, with forwarding across a column clash.
// Synchronous active-low reset clears counters, window and result queue and sets
// width 640 and height 480; the line store keeps its contents.
module hysteresis_edge_link_3x3 import hel_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             i_pixel_class,
    output logic                   empty,
    input  logic                   pop,
    output logic [7:0]             o_pixel_value,
    output logic                   o_last_pixel,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ((CW + 1) > WIDTH_REG_W) ? (CW + 1) : WIDTH_REG_W;
    localparam int UW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [WW-1:0]           width_eff;
    logic [HEIGHT_REG_W-1:0] height_eff;

    logic          accept, reserve, res_valid, pop_ok;
    logic [UW-1:0] r_used;
    t_result       result, head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RESET_WIDTH;
            r_height <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_REG_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_width == '0) begin
            width_eff = WW'(1);
        end else if (WW'(r_width) > WW'(MAX_WIDTH)) begin
            width_eff = WW'(MAX_WIDTH);
        end else begin
            width_eff = WW'(r_width);
        end
    end

    assign height_eff = (r_height == '0) ? HEIGHT_REG_W'(1) : r_height;

    // A queue slot is reserved when an item that will produce a result is taken.
    assign full   = (r_used == UW'(QUEUE_DEPTH));
    assign accept = push && !full;
    assign pop_ok = pop && !empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= r_used + UW'(reserve) - UW'(pop_ok);
        end
    end

    hel_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_class     (i_pixel_class),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .i_restart   (i_cfg_we),
        .o_reserve   (reserve),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    hel_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (result),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head)
    );

    assign o_pixel_value = head.value;
    assign o_last_pixel  = head.last;

endmodule
